// ----- hw/rtl/scm_pkg.sv -----
package scm_pkg;

  // Position arithmetic widths.
  localparam int POS_W  = 32;
  localparam int DW     = POS_W + 1;
  localparam int QW     = DW - 6;

  // Division of a span by 100, one chunk of the dividend per cycle. Each step
  // divides {remainder, chunk}, which stays below 204800, by reciprocal
  // multiplication: floor(t / 100) == (t * 335545) >> 25 for every t below 204800.
  localparam int DIV_CHUNKS   = 3;
  localparam int DIV_CHUNK_W  = (DW + DIV_CHUNKS - 1) / DIV_CHUNKS;
  localparam int DIV_PAD_W    = DIV_CHUNK_W * DIV_CHUNKS;
  localparam int DIV_T_W      = DIV_CHUNK_W + 7;
  localparam int DIV_STEP_W   = $clog2(DIV_CHUNKS + 1);
  localparam int DIV_RECIP_W  = 19;
  localparam int DIV_RECIP_SH = 25;
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 19'd335545;

  // Division by 100 of a small product by reciprocal multiplication:
  // floor(x / 100) == (x * 5243) >> 19 for every x below 12800.
  localparam int RKW      = 20;
  localparam int RECIP_SH = 19;
  localparam logic [6:0]  DIVISOR = 7'd100;
  localparam logic [12:0] RECIP   = 13'd5243;
  localparam logic [8:0]  STEER_SPAN = 9'd100;

  localparam logic [6:0] STEER_SPEED = 7'd80;

  localparam logic [15:0] LIMIT_WAIT_RST  = 16'd2000;
  localparam logic [15:0] READ_WAIT_RST   = 16'd400;
  localparam logic [15:0] CENTER_WAIT_RST = 16'd400;
  localparam logic [6:0]  CALIB_SPEED_RST = 7'd40;
  localparam logic [6:0]  DEAD_BAND_RST   = 7'd5;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_STEER  = 2'd1,
    CMD_REPORT = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_SPEED   = 2'd1,
    OP_REQ_POS = 2'd2,
    OP_HOLD    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_LIMIT_WAIT  = 3'd0,
    REG_READ_WAIT   = 3'd1,
    REG_CENTER_WAIT = 3'd2,
    REG_CALIB_SPEED = 3'd3,
    REG_DEAD_BAND   = 3'd4
  } reg_idx_t;

  typedef enum logic [8:0] {
    PH_IDLE       = 9'b000000001,
    PH_LEFT       = 9'b000000010,
    PH_WAIT_LEFT  = 9'b000000100,
    PH_READ_LEFT  = 9'b000001000,
    PH_RIGHT      = 9'b000010000,
    PH_WAIT_RIGHT = 9'b000100000,
    PH_READ_RIGHT = 9'b001000000,
    PH_CENTER     = 9'b010000000,
    PH_DONE       = 9'b100000000
  } phase_t;

  // Calibration results used by the request mapper. Each span is kept as
  // quotient by 100, scaled remainder and sign.
  typedef struct packed {
    logic [POS_W-1:0] left_end;
    logic [POS_W-1:0] center_pos;
    logic [QW-1:0]    quot_left;
    logic [RKW-1:0]   frac_left;
    logic             neg_left;
    logic [QW-1:0]    quot_right;
    logic [RKW-1:0]   frac_right;
    logic             neg_right;
  } cal_t;

endpackage

// ----- hw/rtl/scm_div100.sv -----
module scm_div100 (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [scm_pkg::DW-1:0] dividend,
  output logic                   done,
  output logic [scm_pkg::QW-1:0] quot,
  output logic [6:0]             rem
);
  import scm_pkg::*;

  logic [DIV_PAD_W-1:0]             dvd;
  logic [DIV_PAD_W-1:0]             quot_acc;
  logic [6:0]                       rem_acc;
  logic [DIV_STEP_W-1:0]            step;
  logic                             run;
  logic [DIV_T_W-1:0]               trial;
  logic [DIV_T_W+DIV_RECIP_W-1:0]   trial_prod;
  logic [DIV_CHUNK_W-1:0]           q_chunk;
  logic [DIV_T_W-1:0]               q_times;
  logic [6:0]                       r_chunk;

  // Long division by 100 in chunks, most significant chunk first. The
  // running remainder joins the next chunk, and that small value is divided
  // by reciprocal multiplication.
  assign trial      = {rem_acc, dvd[DIV_PAD_W-1 -: DIV_CHUNK_W]};
  assign trial_prod = (DIV_T_W + DIV_RECIP_W)'(trial)
                      * (DIV_T_W + DIV_RECIP_W)'(DIV_RECIP);
  assign q_chunk    = trial_prod[DIV_RECIP_SH +: DIV_CHUNK_W];
  assign q_times    = DIV_T_W'(q_chunk) * DIV_T_W'(DIVISOR);
  assign r_chunk    = 7'(trial - q_times);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= DIV_STEP_W'(DIV_CHUNKS);
      end else if (run) begin
        step <= step - DIV_STEP_W'(1);
        if (step == DIV_STEP_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= DIV_PAD_W'(dividend);
      quot_acc <= '0;
      rem_acc  <= '0;
    end else if (run) begin
      dvd      <= {dvd[DIV_PAD_W-DIV_CHUNK_W-1:0], DIV_CHUNK_W'(0)};
      quot_acc <= {quot_acc[DIV_PAD_W-DIV_CHUNK_W-1:0], q_chunk};
      rem_acc  <= r_chunk;
    end
  end

  assign quot = quot_acc[QW-1:0];
  assign rem  = rem_acc;

endmodule

// ----- hw/rtl/scm_map.sv -----
module scm_map (
  input  logic [7:0]                steer,
  input  scm_pkg::cal_t             cal,
  output logic [scm_pkg::POS_W-1:0] target
);
  import scm_pkg::*;

  logic [8:0]        scaled;
  logic [6:0]        scaled_mag;
  logic [QW-1:0]     quot_sel;
  logic [RKW-1:0]    frac_sel;
  logic              span_neg;
  logic [POS_W-1:0]  base;
  logic [QW+6:0]     prod_quot;
  logic [RKW+6:0]    prod_frac;
  logic [QW+6:0]     offset_mag;
  logic [POS_W-1:0]  offset;

  // Left requests interpolate from the left end with weight (s + 100),
  // right requests from center with weight s.
  always_comb begin
    if (steer[7]) begin
      scaled   = {steer[7], steer} + STEER_SPAN;
      quot_sel = cal.quot_left;
      frac_sel = cal.frac_left;
      span_neg = cal.neg_left;
      base     = cal.left_end;
    end else begin
      scaled   = {steer[7], steer};
      quot_sel = cal.quot_right;
      frac_sel = cal.frac_right;
      span_neg = cal.neg_right;
      base     = cal.center_pos;
    end
    scaled_mag = scaled[8] ? 7'(9'd0 - scaled) : scaled[6:0];
  end

  // |w * D| / 100 = |w| * (|D| / 100) + (|w| * (|D| % 100)) / 100
  assign prod_quot  = scaled_mag * quot_sel;
  assign prod_frac  = scaled_mag * frac_sel;
  assign offset_mag = prod_quot + (QW + 7)'(prod_frac[RKW+6:RECIP_SH]);

  // Truncating division: the magnitude is floored, then the sign applied.
  assign offset = (scaled[8] ^ span_neg) ? POS_W'(0) - offset_mag[POS_W-1:0]
                                         : offset_mag[POS_W-1:0];
  assign target = base + offset;

endmodule

// ----- hw/rtl/steering_calibrate_and_map.sv -----
// Steering calibration and request mapper.
// Input beats (item_valid/item_ready) carry cmd: a 1 ms tick, a steering
// request in steer_value, or a motor position report in measured_position.
// Every input beat yields exactly one result beat (result_valid/result_ready)
// with a motor port command: set speed, request position or go to and hold.
// Configuration writes (cfg_valid/cfg_ready, always ready) set the wait times,
// the calibration speed and the dead band, and must be made while idle; the
// block does not enforce this. Beats pass an input register, then the
// sequencer and mapper feeding the result register. One beat is taken per
// cycle unless the receiver stalls or the dividers run. The tick latching the
// right end starts two dividers (one per span, one 11-bit chunk of the span
// per cycle) for the spans divided by 100; the sequencer pauses until both
// are done. When the receiver stalls, the result register holds its beat and
// one more beat waits in the input register; further beats are not taken.
// Reset (rst, synchronous) restores the default configuration, returns the
// sequencer to idle, clears all positions and empties both registers.
module steering_calibrate_and_map (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic [1:0]        cmd,
  input  logic signed [7:0] steer_value,
  input  logic signed [31:0] measured_position,
  output logic              result_valid,
  input  logic              result_ready,
  output logic [1:0]        port_op,
  output logic signed [7:0] speed_value,
  output logic signed [31:0] target_position,
  output logic [6:0]        hold_speed,
  output logic              ready_res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import scm_pkg::*;

  // Configuration
  logic [15:0] limit_wait_ms;
  logic [15:0] read_wait_ms;
  logic [15:0] center_wait_ms;
  logic [6:0]  calib_speed;
  logic [6:0]  dead_band;

  // Input register
  logic             s0_valid;
  logic [1:0]       s0_cmd;
  logic [7:0]       s0_steer;
  logic [POS_W-1:0] s0_pos;

  // Sequencer state
  phase_t           phase, phase_next;
  logic [15:0]      wait_count, wait_count_next;
  logic [POS_W-1:0] left_end, left_end_next;
  logic [POS_W-1:0] right_end, right_end_next;
  logic [POS_W-1:0] center_pos, center_pos_next;
  logic [POS_W-1:0] latched_position, latched_position_next;
  logic [7:0]       requested_steer, requested_steer_next;
  logic [7:0]       applied_steer, applied_steer_next;

  // Span calibration
  logic          cal_busy;
  logic          div_start;
  logic          start_cal;
  logic [QW-1:0] quot_left, quot_right;
  logic [RKW-1:0] frac_left, frac_right;
  logic          neg_left, neg_right;
  logic [DW-1:0] span_left, span_right;
  logic [DW-1:0] abs_left, abs_right;
  logic          done_left, done_right;
  logic [QW-1:0] div_quot_left, div_quot_right;
  logic [6:0]    div_rem_left, div_rem_right;
  logic [RKW-1:0] frac_left_next, frac_right_next;
  cal_t          cal;

  // Step logic
  logic             advance;
  logic [DW-1:0]    end_diff;
  logic [DW-1:0]    end_dist;
  logic [7:0]       steer_mag;
  logic [POS_W-1:0] map_target;
  op_t              op;
  logic [7:0]       spd;
  logic [POS_W-1:0] tgt;
  logic [6:0]       hs;

  // Result register
  op_t              res_op;
  logic [7:0]       res_spd;
  logic signed [POS_W-1:0] res_tgt;
  logic [6:0]       res_hs;
  logic             res_rdy;

  assign cfg_ready  = 1'b1;
  assign advance    = s0_valid && (!result_valid || result_ready) && !cal_busy;
  assign item_ready = !s0_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_wait_ms  <= LIMIT_WAIT_RST;
      read_wait_ms   <= READ_WAIT_RST;
      center_wait_ms <= CENTER_WAIT_RST;
      calib_speed    <= CALIB_SPEED_RST;
      dead_band      <= DEAD_BAND_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LIMIT_WAIT:  limit_wait_ms  <= cfg_data;
        REG_READ_WAIT:   read_wait_ms   <= cfg_data;
        REG_CENTER_WAIT: center_wait_ms <= cfg_data;
        REG_CALIB_SPEED: calib_speed    <= cfg_data[6:0];
        REG_DEAD_BAND:   dead_band      <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      s0_valid <= 1'b1;
    end else if (advance) begin
      s0_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s0_cmd   <= cmd;
      s0_steer <= steer_value;
      s0_pos   <= measured_position[POS_W-1:0];
    end
  end

  // Center is left + |left - right| / 2, taken modulo the position width.
  assign end_diff = {left_end[POS_W-1], left_end} - {latched_position[POS_W-1], latched_position};
  assign end_dist = end_diff[DW-1] ? DW'(0) - end_diff : end_diff;
  assign steer_mag = requested_steer[7] ? 8'd0 - requested_steer : requested_steer;

  always_comb begin
    phase_next            = phase;
    wait_count_next       = wait_count;
    left_end_next         = left_end;
    right_end_next        = right_end;
    center_pos_next       = center_pos;
    latched_position_next = latched_position;
    requested_steer_next  = requested_steer;
    applied_steer_next    = applied_steer;
    start_cal             = 1'b0;
    op                    = OP_NONE;
    spd                   = 8'd0;
    tgt                   = '0;
    hs                    = 7'd0;
    case (s0_cmd)
      CMD_STEER:  requested_steer_next  = s0_steer;
      CMD_REPORT: latched_position_next = s0_pos;
      CMD_TICK: begin
        if (wait_count > 16'd1) begin
          wait_count_next = wait_count - 16'd1;
        end else begin
          wait_count_next = 16'd0;
          case (phase)
            PH_IDLE: phase_next = PH_LEFT;
            PH_LEFT: begin
              op              = OP_SPEED;
              spd             = 8'd0 - {1'b0, calib_speed};
              hs              = calib_speed;
              wait_count_next = limit_wait_ms;
              phase_next      = PH_WAIT_LEFT;
            end
            PH_RIGHT: begin
              op              = OP_SPEED;
              spd             = {1'b0, calib_speed};
              hs              = calib_speed;
              wait_count_next = limit_wait_ms;
              phase_next      = PH_WAIT_RIGHT;
            end
            PH_WAIT_LEFT: begin
              op              = OP_REQ_POS;
              wait_count_next = read_wait_ms;
              phase_next      = PH_READ_LEFT;
            end
            PH_WAIT_RIGHT: begin
              op              = OP_REQ_POS;
              wait_count_next = read_wait_ms;
              phase_next      = PH_READ_RIGHT;
            end
            PH_READ_LEFT: begin
              left_end_next = latched_position;
              phase_next    = PH_RIGHT;
            end
            PH_READ_RIGHT: begin
              right_end_next  = latched_position;
              center_pos_next = left_end + end_dist[POS_W:1];
              start_cal       = 1'b1;
              phase_next      = PH_CENTER;
            end
            PH_CENTER: begin
              op              = OP_HOLD;
              tgt             = center_pos;
              hs              = calib_speed;
              wait_count_next = center_wait_ms;
              phase_next      = PH_DONE;
            end
            PH_DONE: begin
              if (requested_steer != applied_steer) begin
                applied_steer_next = requested_steer;
                op  = OP_HOLD;
                hs  = STEER_SPEED;
                tgt = (steer_mag > {1'b0, dead_band}) ? map_target : center_pos;
              end
            end
            default: phase_next = PH_IDLE;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      wait_count       <= '0;
      left_end         <= '0;
      right_end        <= '0;
      center_pos       <= '0;
      latched_position <= '0;
      requested_steer  <= '0;
      applied_steer    <= '0;
    end else if (advance) begin
      phase            <= phase_next;
      wait_count       <= wait_count_next;
      left_end         <= left_end_next;
      right_end        <= right_end_next;
      center_pos       <= center_pos_next;
      latched_position <= latched_position_next;
      requested_steer  <= requested_steer_next;
      applied_steer    <= applied_steer_next;
    end
  end

  // The dividers start in the cycle after the right end is latched, from the
  // registered ends and center.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_busy  <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= advance && start_cal;
      if (advance && start_cal) begin
        cal_busy <= 1'b1;
      end else if (done_left && done_right) begin
        cal_busy <= 1'b0;
      end
    end
  end

  assign span_left  = {center_pos[POS_W-1], center_pos} - {left_end[POS_W-1], left_end};
  assign span_right = {right_end[POS_W-1], right_end} - {center_pos[POS_W-1], center_pos};
  assign abs_left   = span_left[DW-1]  ? DW'(0) - span_left  : span_left;
  assign abs_right  = span_right[DW-1] ? DW'(0) - span_right : span_right;

  scm_div100 u_div_left (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (abs_left),
    .done     (done_left),
    .quot     (div_quot_left),
    .rem      (div_rem_left)
  );

  scm_div100 u_div_right (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (abs_right),
    .done     (done_right),
    .quot     (div_quot_right),
    .rem      (div_rem_right)
  );

  assign frac_left_next  = div_rem_left * RECIP;
  assign frac_right_next = div_rem_right * RECIP;

  always_ff @(posedge clk) begin
    if (div_start) begin
      neg_left  <= span_left[DW-1];
      neg_right <= span_right[DW-1];
    end
    if (done_left) begin
      quot_left <= div_quot_left;
      frac_left <= frac_left_next;
    end
    if (done_right) begin
      quot_right <= div_quot_right;
      frac_right <= frac_right_next;
    end
  end

  assign cal.left_end   = left_end;
  assign cal.center_pos = center_pos;
  assign cal.quot_left  = quot_left;
  assign cal.frac_left  = frac_left;
  assign cal.neg_left   = neg_left;
  assign cal.quot_right = quot_right;
  assign cal.frac_right = frac_right;
  assign cal.neg_right  = neg_right;

  scm_map u_map (
    .steer  (requested_steer),
    .cal    (cal),
    .target (map_target)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_op  <= op;
      res_spd <= spd;
      res_tgt <= tgt;
      res_hs  <= hs;
      res_rdy <= (phase_next == PH_DONE);
    end
  end

  assign port_op         = res_op;
  assign speed_value     = res_spd;
  assign target_position = 32'(res_tgt);
  assign hold_speed      = res_hs;
  assign ready_res       = res_rdy;

endmodule

// ----- sim/steer_checker.sv -----
module steer_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_ready,
  input  logic [1:0]         cmd,
  input  logic signed [7:0]  steer_value,
  input  logic signed [31:0] measured_position,
  input  logic               result_valid,
  input  logic               result_ready,
  input  logic [1:0]         port_op,
  input  logic signed [7:0]  speed_value,
  input  logic signed [31:0] target_position,
  input  logic [6:0]         hold_speed,
  input  logic               ready_res,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 mismatches,
  output int                 outstanding
);
  import scm_pkg::*;

  localparam longint SPAN = 100;

  typedef struct packed {
    op_t                op;
    logic signed [7:0]  speed;
    logic signed [31:0] target;
    logic [6:0]         hspeed;
    logic               rdy;
  } port_cmd_t;

  port_cmd_t port_cmd_q[$];

  logic [15:0] limit_wait, read_wait, center_wait;
  logic [6:0]  calib_speed, dead_band;

  phase_t             seq_phase;
  logic [15:0]        tick_wait;
  logic signed [31:0] left_stop, right_stop, center, last_report;
  logic signed [7:0]  steer_req, steer_applied;

  function automatic port_cmd_t predict_port_command(input logic [1:0] c,
                                                     input logic signed [7:0] s,
                                                     input logic signed [31:0] p);
    port_cmd_t         r;
    logic signed [7:0] spd;
    longint            span;
    longint            pos;
    int                mag;
    r = '0;
    case (c)
      CMD_STEER: steer_req = s;
      CMD_REPORT: last_report = p;
      CMD_TICK: begin
        // A wait of d ticks lets d-1 ticks pass; the d-th one acts.
        if (tick_wait > 16'd1) begin
          tick_wait = tick_wait - 16'd1;
        end else begin
          tick_wait = '0;
          case (seq_phase)
            PH_IDLE: seq_phase = PH_LEFT;
            PH_LEFT, PH_RIGHT: begin
              spd = {1'b0, calib_speed};
              r.op = OP_SPEED;
              r.hspeed = calib_speed;
              tick_wait = limit_wait;
              if (seq_phase == PH_LEFT) begin
                r.speed = -spd;
                seq_phase = PH_WAIT_LEFT;
              end else begin
                r.speed = spd;
                seq_phase = PH_WAIT_RIGHT;
              end
            end
            PH_WAIT_LEFT, PH_WAIT_RIGHT: begin
              r.op = OP_REQ_POS;
              tick_wait = read_wait;
              if (seq_phase == PH_WAIT_LEFT) begin
                seq_phase = PH_READ_LEFT;
              end else begin
                seq_phase = PH_READ_RIGHT;
              end
            end
            PH_READ_LEFT: begin
              left_stop = last_report;
              seq_phase = PH_RIGHT;
            end
            PH_READ_RIGHT: begin
              right_stop = last_report;
              span = longint'(left_stop) - longint'(right_stop);
              if (span < 0) begin
                span = -span;
              end
              pos = longint'(left_stop) + span / 2;
              center = pos[31:0];
              seq_phase = PH_CENTER;
            end
            PH_CENTER: begin
              r.op = OP_HOLD;
              r.target = center;
              r.hspeed = calib_speed;
              tick_wait = center_wait;
              seq_phase = PH_DONE;
            end
            PH_DONE: begin
              if (steer_req != steer_applied) begin
                steer_applied = steer_req;
                mag = (steer_req < 0) ? -int'(steer_req) : int'(steer_req);
                pos = center;
                // Outside the dead band the target moves linearly from center
                // toward the end on the requested side, truncating toward zero.
                if (mag > int'(dead_band)) begin
                  if (steer_req < 0) begin
                    pos = (longint'(steer_req) + SPAN)
                          * (longint'(center) - longint'(left_stop)) / SPAN
                          + longint'(left_stop);
                  end else begin
                    pos = longint'(steer_req)
                          * (longint'(right_stop) - longint'(center)) / SPAN
                          + longint'(center);
                  end
                end
                r.op = OP_HOLD;
                r.target = pos[31:0];
                r.hspeed = STEER_SPEED;
              end
            end
            default: seq_phase = PH_IDLE;
          endcase
        end
      end
      default: ;
    endcase
    r.rdy = (seq_phase == PH_DONE);
    return r;
  endfunction

  task automatic compare_field(input string what, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    port_cmd_t want;
    if (rst) begin
      limit_wait    = LIMIT_WAIT_RST;
      read_wait     = READ_WAIT_RST;
      center_wait   = CENTER_WAIT_RST;
      calib_speed   = CALIB_SPEED_RST;
      dead_band     = DEAD_BAND_RST;
      seq_phase     = PH_IDLE;
      tick_wait     = '0;
      left_stop     = '0;
      right_stop    = '0;
      center        = '0;
      last_report   = '0;
      steer_req     = '0;
      steer_applied = '0;
      mismatches    = 0;
      port_cmd_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LIMIT_WAIT:  limit_wait = cfg_data;
          REG_READ_WAIT:   read_wait = cfg_data;
          REG_CENTER_WAIT: center_wait = cfg_data;
          REG_CALIB_SPEED: calib_speed = cfg_data[6:0];
          REG_DEAD_BAND:   dead_band = cfg_data[6:0];
          default: ;
        endcase
      end
      if (item_valid && item_ready) begin
        port_cmd_q.push_back(predict_port_command(cmd, steer_value, measured_position));
      end
      if (result_valid && result_ready) begin
        if (port_cmd_q.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing expected, expected none, got port_op %0d",
                   $time, port_op);
        end else begin
          want = port_cmd_q.pop_front();
          compare_field("port_op", want.op, port_op);
          compare_field("speed_value", want.speed, speed_value);
          compare_field("target_position", want.target, target_position);
          compare_field("hold_speed", want.hspeed, hold_speed);
          compare_field("ready_res", want.rdy, ready_res);
        end
      end
    end
    outstanding <= port_cmd_q.size();
  end

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
  import scm_pkg::*;

  localparam int         LIMIT_CYCLES = 400000;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         STAGE_BEATS  = 570;
  localparam int         LONG_HOLD    = 150;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam logic [2:0] REG_UNUSED   = 3'd7;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  logic [1:0]         cmd = CMD_TICK;
  logic signed [7:0]  steer_value = '0;
  logic signed [31:0] measured_position = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic [1:0]         port_op;
  logic signed [7:0]  speed_value;
  logic signed [31:0] target_position;
  logic [6:0]         hold_speed;
  logic               ready_res;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = REG_LIMIT_WAIT;
  logic [15:0]        cfg_data = '0;

  int   tx_idle_pct = 16;
  int   rx_idle_pct = 75;
  logic long_hold_req = 1'b0;
  logic long_hold_done = 1'b0;
  int   hold_left = 0;
  int   cycles = 0;
  int   beats_sent = 0;
  int   writes_done = 0;
  int   db_now = DEAD_BAND_RST;
  int   mismatches;
  int   outstanding;

  logic signed [31:0] left_val, right_val;
  logic signed [7:0]  probe_steer [9] = '{-8'sd100, 8'sd100, 8'sd0, 8'sd5, 8'sd6,
                                          -8'sd5, -8'sd6, 8'sh80, 8'sd127};

  steering_calibrate_and_map DUT (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (item_valid),
    .item_ready        (item_ready),
    .cmd               (cmd),
    .steer_value       (steer_value),
    .measured_position (measured_position),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .port_op           (port_op),
    .speed_value       (speed_value),
    .target_position   (target_position),
    .hold_speed        (hold_speed),
    .ready_res         (ready_res),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  steer_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (item_valid),
    .item_ready        (item_ready),
    .cmd               (cmd),
    .steer_value       (steer_value),
    .measured_position (measured_position),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .port_op           (port_op),
    .speed_value       (speed_value),
    .target_position   (target_position),
    .hold_speed        (hold_speed),
    .ready_res         (ready_res),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatches        (mismatches),
    .outstanding       (outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles, outstanding);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off that fills the block.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      result_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_hold_req && !long_hold_done) begin
      result_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else begin
      result_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_item(input logic [1:0] c, input logic signed [7:0] s,
                           input logic signed [31:0] p);
    if ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    item_valid <= 1'b1;
    cmd <= c;
    steer_value <= s;
    measured_position <= p;
    do @(posedge clk); while (!item_ready);
    beats_sent++;
  endtask

  // Unused payload fields carry random values on every beat.
  task automatic send_tick();
    send_item(CMD_TICK, 8'($urandom), $urandom);
  endtask

  task automatic send_steer(input logic signed [7:0] s);
    send_item(CMD_STEER, s, $urandom);
  endtask

  task automatic send_report(input logic signed [31:0] p);
    send_item(CMD_REPORT, 8'($urandom), p);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    writes_done++;
  endtask

  // The extra cycles cover the divider pass after the right end is latched.
  task automatic wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    int                pick;
    int                mag;
    logic signed [7:0] s;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        case ($urandom_range(5))
          0: s = 8'($urandom);
          1: begin
            mag = db_now - 1 + int'($urandom_range(2));
            s = 8'(($urandom_range(1) != 0) ? mag : -mag);
          end
          default: s = 8'(int'($urandom_range(200)) - 100);
        endcase
        send_steer(s);
      end else if (pick < 80) begin
        send_tick();
      end else if (pick < 93) begin
        send_report($urandom);
      end else begin
        send_item(CMD_UNUSED, 8'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    case ($urandom_range(3))
      0: begin
        left_val = 32'sh8000_0000;
        right_val = 32'sh7fff_ffff;
      end
      1: begin
        // Reversed extremes make the center wrap.
        left_val = 32'sh7fff_ffff;
        right_val = 32'sh8000_0000;
      end
      2: begin
        left_val = $urandom;
        right_val = $urandom;
      end
      default: begin
        left_val = 0 - int'($urandom_range(5000));
        right_val = $urandom_range(5000);
      end
    endcase

    // Left seek runs with the reset speed and a one-tick limit wait.
    write_reg(REG_LIMIT_WAIT, 16'd1);
    write_reg(REG_READ_WAIT, 16'd2);
    write_reg(REG_UNUSED, 16'hffff);
    cfg_valid <= 1'b0;
    send_tick();
    send_tick();
    send_report(32'sh7fff_ffff);
    send_steer(8'sd100);
    send_item(CMD_UNUSED, 8'sh80, 32'sh8000_0000);
    send_tick();
    send_report(left_val);
    send_tick();
    send_tick();
    wait_idle();

    // Right seek with a zero limit wait and a speed beyond the usual range.
    write_reg(REG_CALIB_SPEED, 16'd127);
    write_reg(REG_LIMIT_WAIT, 16'd0);
    write_reg(REG_READ_WAIT, 16'd1);
    write_reg(REG_CENTER_WAIT, 16'd2);
    cfg_valid <= 1'b0;
    send_tick();
    send_tick();
    send_report(32'sh8000_0000);
    send_report(right_val);
    send_tick();
    send_tick();
    foreach (probe_steer[i]) begin
      send_steer(probe_steer[i]);
      send_tick();
    end
    send_tick();
    wait_idle();

    write_reg(REG_DEAD_BAND, 16'd0);
    db_now = 0;
    write_reg(REG_LIMIT_WAIT, 16'hffff);
    write_reg(REG_READ_WAIT, 16'hffff);
    write_reg(REG_CENTER_WAIT, 16'hffff);
    write_reg(REG_CALIB_SPEED, 16'd0);
    cfg_valid <= 1'b0;
    run_random(STAGE_BEATS);
    wait_idle();

    write_reg(REG_DEAD_BAND, 16'd100);
    db_now = 100;
    cfg_valid <= 1'b0;
    tx_idle_pct = 75;
    rx_idle_pct <= 16;
    run_random(STAGE_BEATS);
    wait_idle();

    db_now = $urandom_range(127);
    write_reg(REG_DEAD_BAND, 16'(db_now));
    cfg_valid <= 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    long_hold_req <= 1'b1;
    run_random(STAGE_BEATS);
    wait_idle();

    $display("Calibrated with ends %0d and %0d, then mapped requests", left_val, right_val);
    $display("under dead bands 5, 0, 100 and %0d.", db_now);
    $display("Sent %0d input beats and %0d register writes in %0d cycles.",
             beats_sent, writes_done, cycles);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
